// ----- sv/ttw_pkg.sv -----
// Package for the text terminal writer: cell, command and result types,
// operation and state codes, reset constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttw_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  localparam logic [4:0] RowsReset   = 5'd25;
  localparam logic [7:0] BlankAttr   = 8'h07;
  localparam logic [7:0] NewlineCode = 8'h0a;

  typedef enum logic [1:0] {
    OP_PRINT      = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_READ       = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL
  } state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  localparam cell_t BlankCell = '{ch: 8'h00, attr: BlankAttr};

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [6:0] column;
    logic [4:0] row;
  } cmd_t;

  typedef struct packed {
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic [7:0] read_char;
    logic [7:0] read_attribute;
    logic       scrolled;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_status_t;

endpackage

`default_nettype wire

// ----- sv/ttw_cell_mem.sv -----
// Character/attribute cell store: one write port, one read port, registered read.
// Depends on ttw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttw_cell_mem import ttw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows,
  localparam int Cells  = ROWS * COLUMNS,
  localparam int AW     = $clog2(Cells)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire cell_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output cell_t              rdata_o
);

  cell_t mem [Cells];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/ttw_sweep.sv -----
// Sweep engine: walks the cell store one cell a cycle, copying each cell one row
// up below the copy limit and blanking it from there on. Depends on ttw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttw_sweep import ttw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows,
  localparam int Cells  = ROWS * COLUMNS,
  localparam int AW     = $clog2(Cells),
  localparam int CW     = $clog2(Cells + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [CW-1:0] copy_end_i,
  input  wire logic [CW-1:0] end_i,
  input  wire cell_t         rdata_i,
  output logic [AW-1:0]      raddr_o,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output cell_t              wdata_o,
  output sweep_status_t      status_o
);

  logic          active_q;
  logic [CW-1:0] cnt_q, copy_end_q, end_q;
  logic          pend_q;
  logic          pend_blank_q;
  logic [AW-1:0] pend_addr_q;
  logic          issue;

  assign issue   = active_q && (cnt_q != end_q);
  assign raddr_o = AW'(32'(cnt_q) + COLUMNS);
  assign we_o    = pend_q;
  assign waddr_o = pend_addr_q;
  assign wdata_o = pend_blank_q ? BlankCell : rdata_i;

  always_comb begin
    status_o.busy = active_q;
    status_o.done = active_q && !issue && !pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      pend_q <= issue;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (status_o.done) begin
        active_q <= 1'b0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      copy_end_q <= copy_end_i;
      end_q      <= end_i;
    end
    pend_blank_q <= cnt_q >= copy_end_q;
    pend_addr_q  <= AW'(cnt_q);
  end

endmodule

`default_nettype wire

// ----- sv/text_terminal_writer.sv -----
// Text terminal writer: a print is accepted, then the execute state writes the cell
// into the single-port-write store; a pending wrap adds an execute step first. A scroll
// walks the window through the store one cell a cycle, and the item then resumes in
// the execute state; a newline after a pending wrap may scroll twice. Set cursor and
// read are accepted, then finish in the execute state. After reset the whole store is
// cleared with busy high. Each result is shown for one cycle on done_o and cannot be
// held off.
// Depends on ttw_pkg, ttw_cell_mem and ttw_sweep.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_writer import ttw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire cmd_t       cmd_i,
  output logic            done_o,
  output result_t         result_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [4:0] cfg_data_i
);

  localparam int Cells = ROWS * COLUMNS;
  localparam int AW    = $clog2(Cells);
  localparam int CW    = $clog2(Cells + 1);
  localparam int XW    = $clog2(COLUMNS + 1);

  state_e        state_q, state_d;
  logic [4:0]    rows_q;
  logic [4:0]    rows_eff, rows_last, y_eff;
  logic [XW-1:0] cur_x_q, cur_x_d;
  logic [4:0]    cur_y_q, cur_y_d;
  logic [1:0]    op_q;
  logic [7:0]    ch_q, at_q;
  logic [XW-1:0] col_q;
  logic [4:0]    row_q;
  logic          wrap_done_q, wrap_done_d;
  logic          nl_done_q, nl_done_d;
  logic          scrolled_q, scrolled_d;
  logic          done_d;
  result_t       res_d;
  logic          accept;
  logic [6:0]    col_c;
  logic [4:0]    row_c;
  logic [AW-1:0] item_raddr, mem_raddr, mem_waddr, exec_waddr;
  logic          exec_we, mem_we;
  cell_t         mem_wdata, mem_rdata, exec_wdata;
  logic          sweep_start;
  logic [CW-1:0] sweep_copy_end, sweep_end;
  logic [AW-1:0] sweep_raddr, sweep_waddr;
  logic          sweep_we;
  cell_t         sweep_wdata;
  sweep_status_t sweep_stat;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;

  always_comb begin
    if (rows_q == 5'd0) begin
      rows_eff = 5'd1;
    end else if (32'(rows_q) > ROWS) begin
      rows_eff = 5'(ROWS);
    end else begin
      rows_eff = rows_q;
    end
    rows_last = rows_eff - 5'd1;
    y_eff     = (cur_y_q >= rows_eff) ? rows_last : cur_y_q;
    col_c     = (32'(cmd_i.column) >= COLUMNS) ? 7'(COLUMNS - 1) : cmd_i.column;
    row_c     = (cmd_i.row >= rows_eff) ? rows_last : cmd_i.row;
  end

  assign item_raddr = AW'(32'(row_c) * COLUMNS + 32'(col_c));
  assign exec_waddr = AW'(32'(y_eff) * COLUMNS + 32'(cur_x_q));
  assign exec_wdata = '{ch: ch_q, attr: at_q};

  assign mem_raddr = sweep_stat.busy ? sweep_raddr : item_raddr;
  assign mem_we    = sweep_we || exec_we;
  assign mem_waddr = sweep_we ? sweep_waddr : exec_waddr;
  assign mem_wdata = sweep_we ? sweep_wdata : exec_wdata;

  ttw_cell_mem #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ttw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sweep_start),
    .copy_end_i (sweep_copy_end),
    .end_i      (sweep_end),
    .rdata_i    (mem_rdata),
    .raddr_o    (sweep_raddr),
    .we_o       (sweep_we),
    .waddr_o    (sweep_waddr),
    .wdata_o    (sweep_wdata),
    .status_o   (sweep_stat)
  );

  always_comb begin
    state_d        = state_q;
    cur_x_d        = cur_x_q;
    cur_y_d        = cur_y_q;
    wrap_done_d    = wrap_done_q;
    nl_done_d      = nl_done_q;
    scrolled_d     = scrolled_q;
    done_d         = 1'b0;
    exec_we        = 1'b0;
    sweep_start    = 1'b0;
    sweep_copy_end = CW'(32'(rows_last) * COLUMNS);
    sweep_end      = CW'(32'(rows_eff) * COLUMNS);
    case (state_q)
      ST_INIT: begin
        sweep_start    = 1'b1;
        sweep_copy_end = '0;
        sweep_end      = CW'(Cells);
        state_d        = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sweep_stat.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          wrap_done_d = 1'b0;
          nl_done_d   = 1'b0;
          scrolled_d  = 1'b0;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_PRINT: begin
            cur_y_d = y_eff;
            if (nl_done_q) begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else if (!wrap_done_q && (32'(cur_x_q) >= COLUMNS)) begin
              wrap_done_d = 1'b1;
              cur_x_d     = '0;
              if (y_eff == rows_last) begin
                scrolled_d  = 1'b1;
                sweep_start = 1'b1;
                state_d     = ST_SCROLL;
              end else begin
                cur_y_d = y_eff + 5'd1;
              end
            end else if (ch_q == NewlineCode) begin
              nl_done_d = 1'b1;
              cur_x_d   = '0;
              if (y_eff == rows_last) begin
                scrolled_d  = 1'b1;
                sweep_start = 1'b1;
                state_d     = ST_SCROLL;
              end else begin
                cur_y_d = y_eff + 5'd1;
                done_d  = 1'b1;
                state_d = ST_IDLE;
              end
            end else begin
              exec_we = 1'b1;
              cur_x_d = cur_x_q + 1'b1;
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          OP_SET_CURSOR: begin
            cur_x_d = col_q;
            cur_y_d = row_q;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
          default: begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCROLL: begin
        if (sweep_stat.done) begin
          state_d = ST_EXEC;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase

    res_d.cursor_column  = 7'(cur_x_d);
    res_d.cursor_row     = cur_y_d;
    res_d.read_char      = (op_q == OP_READ) ? mem_rdata.ch : 8'h00;
    res_d.read_attribute = (op_q == OP_READ) ? mem_rdata.attr : 8'h00;
    res_d.scrolled       = scrolled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      rows_q      <= RowsReset;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      wrap_done_q <= 1'b0;
      nl_done_q   <= 1'b0;
      scrolled_q  <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      wrap_done_q <= wrap_done_d;
      nl_done_q   <= nl_done_d;
      scrolled_q  <= scrolled_d;
      done_o      <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rows_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= cmd_i.operation;
      ch_q  <= cmd_i.char_code;
      at_q  <= cmd_i.attribute;
      col_q <= XW'(col_c);
      row_q <= row_c;
    end
    if (done_d) begin
      result_o <= res_d;
    end
  end

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sweep_we && exec_we))
    else $error("sweep and print write the store in the same cycle");

  a_done_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without an execute cycle");

  a_sweep_in_sweep_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_stat.busy |-> (state_q == ST_CLEAR || state_q == ST_SCROLL))
    else $error("sweep running outside clear or scroll");

  a_cursor_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_x_q) <= COLUMNS)
    else $error("cursor column beyond wrap position");

endmodule

`default_nettype wire
